// ===== sv/midi_rs_pkg.sv =====
package midi_rs_pkg;

  // message kinds on the result channel
  localparam logic [1:0] KIND_NOTE_OFF = 2'd0;
  localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
  localparam logic [1:0] KIND_CTRL_CHG = 2'd2;
  localparam logic [1:0] KIND_PROG_CHG = 2'd3;

  // status nibbles
  localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
  localparam logic [3:0] NIB_POLY_PRES = 4'hA;
  localparam logic [3:0] NIB_CTRL_CHG  = 4'hB;
  localparam logic [3:0] NIB_PROG_CHG  = 4'hC;
  localparam logic [3:0] NIB_CHAN_PRES = 4'hD;
  localparam logic [3:0] NIB_PITCH     = 4'hE;
  localparam logic [3:0] NIB_SYSTEM    = 4'hF;

  // system bytes
  localparam logic [7:0] BYTE_REALTIME = 8'hF8;
  localparam logic [7:0] BYTE_SYSEX    = 8'hF0;
  localparam logic [7:0] BYTE_EOX      = 8'hF7;

endpackage

// ===== sv/midi_running_status_parser.sv =====
// channel   direction  handshake          payload
// in_       input      in_valid/in_stall   in_rx_byte[7:0]
// out_      output     out_valid/out_stall out_msg_kind[1:0], out_channel[4:0],
//                                          out_data_first[6:0], out_data_second[6:0]
//
// one byte per cycle sustained while out_stall does not hold a result; a byte is
// registered in the input register and then its result in the result register
// synchronous active-low reset clears the parser state and both valid flags
// a held result under out_stall holds the input register; in_stall rises only
// while the input register is full and the result register cannot move
module midi_running_status_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_msg_kind,
  output logic [4:0] out_channel,
  output logic [6:0] out_data_first,
  output logic [6:0] out_data_second
);

  // input register
  logic       in_full_r, in_full_nxt;
  logic [7:0] byte_r;

  // parser state
  logic       sysex_r, sysex_nxt;
  logic [7:0] status_r, status_nxt;
  logic       count_r, count_nxt;
  logic [6:0] held_r, held_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] kind_r;
  logic [4:0] chan_r;
  logic [6:0] d1_r;
  logic [6:0] d2_r;

  logic       out_free;
  logic       advance;
  logic       accept;
  logic       need2;
  logic       has_kind;
  logic [1:0] kind;
  logic       res;
  logic [6:0] d1;
  logic [6:0] d2;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_full_r && out_free;
  assign in_stall = in_full_r && !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    need2    = 1'b0;
    has_kind = 1'b0;
    kind     = midi_rs_pkg::KIND_NOTE_OFF;
    case (status_r[7:4])
      midi_rs_pkg::NIB_NOTE_OFF: begin
        need2    = 1'b1;
        has_kind = 1'b1;
        kind     = midi_rs_pkg::KIND_NOTE_OFF;
      end
      midi_rs_pkg::NIB_NOTE_ON: begin
        need2    = 1'b1;
        has_kind = 1'b1;
        kind     = midi_rs_pkg::KIND_NOTE_ON;
      end
      midi_rs_pkg::NIB_POLY_PRES: need2 = 1'b1;
      midi_rs_pkg::NIB_CTRL_CHG: begin
        need2    = 1'b1;
        has_kind = 1'b1;
        kind     = midi_rs_pkg::KIND_CTRL_CHG;
      end
      midi_rs_pkg::NIB_PROG_CHG: begin
        has_kind = 1'b1;
        kind     = midi_rs_pkg::KIND_PROG_CHG;
      end
      midi_rs_pkg::NIB_PITCH: need2 = 1'b1;
      default: ;
    endcase
  end

  assign d1 = need2 ? held_r : byte_r[6:0];
  assign d2 = need2 ? byte_r[6:0] : 7'd0;

  always_comb begin
    sysex_nxt  = sysex_r;
    status_nxt = status_r;
    count_nxt  = count_r;
    held_nxt   = held_r;
    res        = 1'b0;
    if (advance) begin
      if (byte_r >= midi_rs_pkg::BYTE_REALTIME) begin
        // real-time, leave everything alone
      end else if (byte_r == midi_rs_pkg::BYTE_SYSEX) begin
        sysex_nxt = 1'b1;
      end else if (sysex_r) begin
        if (byte_r == midi_rs_pkg::BYTE_EOX) sysex_nxt = 1'b0;
      end else if (byte_r[7]) begin
        status_nxt = (byte_r[7:4] == midi_rs_pkg::NIB_SYSTEM) ? 8'd0 : byte_r;
        count_nxt  = 1'b0;
      end else if (status_r != 8'd0) begin
        if (need2 && !count_r) begin
          held_nxt  = byte_r[6:0];
          count_nxt = 1'b1;
        end else begin
          count_nxt = 1'b0;
          res       = has_kind;
        end
      end
    end
  end

  always_comb begin
    if (accept) begin
      in_full_nxt = 1'b1;
    end else if (advance) begin
      in_full_nxt = 1'b0;
    end else begin
      in_full_nxt = in_full_r;
    end
    if (advance) begin
      out_valid_nxt = res;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
      sysex_r     <= 1'b0;
      status_r    <= 8'd0;
      count_r     <= 1'b0;
      held_r      <= 7'd0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
      sysex_r     <= sysex_nxt;
      status_r    <= status_nxt;
      count_r     <= count_nxt;
      held_r      <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) byte_r <= in_rx_byte;
    if (advance && res) begin
      kind_r <= kind;
      chan_r <= {1'b0, status_r[3:0]} + 5'd1;
      d1_r   <= d1;
      d2_r   <= d2;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_msg_kind    = kind_r;
  assign out_channel     = chan_r;
  assign out_data_first  = d1_r;
  assign out_data_second = d2_r;

  // only channel statuses are ever held
  a_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    status_r == 8'd0 || (status_r[7] && status_r[7:4] != midi_rs_pkg::NIB_SYSTEM))
    else $error("running status holds a non-channel byte");

  // a byte waiting on a blocked result is kept
  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_full_r && !out_free |=> in_full_r && $stable(byte_r))
    else $error("pending byte lost while result blocked");

  // every result carries a channel from 1 to 16
  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> chan_r != 5'd0 && chan_r <= 5'd16)
    else $error("channel out of range");

  // program change always carries zero second data
  a_prog_d2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == midi_rs_pkg::KIND_PROG_CHG |-> d2_r == 7'd0)
    else $error("program change with nonzero second data");

endmodule

// ===== tb/midi_running_status_parser_tb.sv =====
module midi_running_status_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] NO_STATUS = 8'h00;
  localparam int RANDOM_WORDS = 650;

  typedef struct {
    logic [7:0] rx;
    int         gap;
    bit         drain;
  } rx_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] channel;
    logic [6:0] first;
    logic [6:0] second;
  } midi_msg_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_msg_kind;
  logic [4:0] out_channel;
  logic [6:0] out_data_first;
  logic [6:0] out_data_second;

  midi_running_status_parser uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_msg_kind   (out_msg_kind),
    .out_channel    (out_channel),
    .out_data_first (out_data_first),
    .out_data_second(out_data_second)
  );

  always #1 clk = ~clk;

  rx_word_t  pend_words[$];
  midi_msg_t expected_msgs[$];
  int        mismatch_cnt = 0;
  int        word_cnt = 0;
  int        idle_mode = 1;
  int        stall_mode = 1;
  bit        drain_next = 1'b0;

  // parser state mirror
  logic       sysex_skip = 1'b0;
  logic [7:0] run_status = NO_STATUS;
  logic [1:0] data_cnt = 2'd0;
  logic [6:0] first_data = 7'd0;

  function automatic void parse_byte(input logic [7:0] b);
    midi_msg_t  m;
    logic       two;
    logic [6:0] d1;
    logic [6:0] d2;
    if (b >= midi_rs_pkg::BYTE_REALTIME) return;
    if (b == midi_rs_pkg::BYTE_SYSEX) begin
      sysex_skip = 1'b1;
      return;
    end
    if (sysex_skip) begin
      if (b == midi_rs_pkg::BYTE_EOX) sysex_skip = 1'b0;
      return;
    end
    if (b[7]) begin
      run_status = (b[7:4] == midi_rs_pkg::NIB_SYSTEM) ? NO_STATUS : b;
      data_cnt = 2'd0;
      return;
    end
    if (run_status == NO_STATUS) return;
    two = !(run_status[7:4] == midi_rs_pkg::NIB_PROG_CHG ||
            run_status[7:4] == midi_rs_pkg::NIB_CHAN_PRES);
    if (two && data_cnt == 2'd0) begin
      first_data = b[6:0];
      data_cnt = 2'd1;
      return;
    end
    d1 = two ? first_data : b[6:0];
    d2 = two ? b[6:0] : 7'd0;
    data_cnt = 2'd0;
    case (run_status[7:4])
      midi_rs_pkg::NIB_NOTE_OFF: m.kind = midi_rs_pkg::KIND_NOTE_OFF;
      midi_rs_pkg::NIB_NOTE_ON:  m.kind = midi_rs_pkg::KIND_NOTE_ON;
      midi_rs_pkg::NIB_CTRL_CHG: m.kind = midi_rs_pkg::KIND_CTRL_CHG;
      midi_rs_pkg::NIB_PROG_CHG: m.kind = midi_rs_pkg::KIND_PROG_CHG;
      default:                   return;
    endcase
    m.channel = {1'b0, run_status[3:0]} + 5'd1;
    m.first = d1;
    m.second = d2;
    expected_msgs.push_back(m);
  endfunction

  function automatic int draw_wait(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 19);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 19) : 0;
    endcase
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    rx_word_t w;
    w.rx = b;
    w.gap = draw_wait(idle_mode);
    w.drain = drain_next;
    drain_next = 1'b0;
    pend_words.push_back(w);
    if (b < midi_rs_pkg::BYTE_REALTIME) word_cnt++;
  endtask

  function automatic logic [7:0] rand_data();
    logic [6:0] d;
    d = 7'($urandom_range(0, 127));
    return {1'b0, d};
  endfunction

  task automatic maybe_realtime();
    logic [2:0] r;
    r = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 9) == 0) queue_byte(midi_rs_pkg::BYTE_REALTIME + {5'd0, r});
  endtask

  // driver
  always @(posedge clk) begin : drive_proc
    logic slot_free;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_rx_byte <= 8'h00;
    end else begin
      slot_free = !in_valid;
      if (in_valid && !in_stall) begin
        parse_byte(in_rx_byte);
        slot_free = 1'b1;
      end
      if (slot_free) begin
        if (pend_words.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pend_words[0].drain && expected_msgs.size() != 0) begin
          in_valid <= 1'b0;
        end else if (pend_words[0].gap != 0) begin
          pend_words[0].gap = pend_words[0].gap - 1;
          in_valid <= 1'b0;
        end else begin
          in_rx_byte <= pend_words[0].rx;
          in_valid <= 1'b1;
          void'(pend_words.pop_front());
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch_proc
    int        stall_left;
    midi_msg_t exp_m;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_msgs.size() == 0) begin
          $display("%0t: unexpected message kind %0d ch %0d d1 %0d d2 %0d", $realtime,
                   out_msg_kind, out_channel, out_data_first, out_data_second);
          mismatch_cnt++;
        end else begin
          exp_m = expected_msgs.pop_front();
          if (out_msg_kind !== exp_m.kind) begin
            $display("%0t: kind expected %0d actual %0d", $realtime, exp_m.kind, out_msg_kind);
            mismatch_cnt++;
          end
          if (out_channel !== exp_m.channel) begin
            $display("%0t: channel expected %0d actual %0d", $realtime, exp_m.channel,
                     out_channel);
            mismatch_cnt++;
          end
          if (out_data_first !== exp_m.first) begin
            $display("%0t: data_first expected %0d actual %0d", $realtime, exp_m.first,
                     out_data_first);
            mismatch_cnt++;
          end
          if (out_data_second !== exp_m.second) begin
            $display("%0t: data_second expected %0d actual %0d", $realtime, exp_m.second,
                     out_data_second);
            mismatch_cnt++;
          end
        end
        if ($urandom_range(0, 15) == 0) stall_mode = $urandom_range(0, 2);
        stall_left = draw_wait(stall_mode);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        if (out_valid) stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stim_proc
    logic [7:0] directed[$] = {
      8'h00,                           // data with no status is dropped
      8'h90, 8'h00, 8'h7F, 8'h7F, 8'h00, // note on, then running status
      8'h8F, 8'h40, 8'hF8, 8'h40,      // real-time byte inside a message
      8'hB7, 8'h07, 8'h64,
      8'hC3, 8'h7F,
      8'hA0, 8'h10, 8'h20,             // types that finish with no message
      8'hE2, 8'h00, 8'h40,
      8'hD1, 8'h33,
      8'h9A, 8'h3C, 8'hF0, 8'h12, 8'hF0, 8'hF7, 8'h64, // sysex inside a half message
      8'hF7, 8'h10,                    // lone eox clears the status
      8'hFF, 8'hF4
    };
    logic [7:0] st;
    logic [3:0] nib;
    logic [3:0] chan;
    int         pick;
    int         n;
    int         next_seg;
    int         next_drain;
    bit         two;

    foreach (directed[i]) queue_byte(directed[i]);
    word_cnt = 0;
    next_seg = 0;
    next_drain = 100;
    while (word_cnt < RANDOM_WORDS) begin
      if (word_cnt >= next_seg) begin
        idle_mode = $urandom_range(0, 2);
        next_seg += 60;
      end
      if (word_cnt >= next_drain) begin
        drain_next = 1'b1;
        next_drain += 220;
      end
      pick = $urandom_range(0, 99);
      nib = 4'($urandom_range(8, 14));
      chan = 4'($urandom_range(0, 15));
      st = {nib, chan};
      two = !(nib == midi_rs_pkg::NIB_PROG_CHG || nib == midi_rs_pkg::NIB_CHAN_PRES);
      if (pick < 60) begin
        // well-formed message, status sometimes left to running status
        if ($urandom_range(0, 3) != 0) queue_byte(st);
        n = $urandom_range(1, 3);
        repeat (n) begin
          queue_byte(rand_data());
          maybe_realtime();
          if (two) queue_byte(rand_data());
        end
      end else if (pick < 72) begin
        if ($urandom_range(0, 1) == 0) begin
          queue_byte({midi_rs_pkg::NIB_NOTE_ON, chan});
          queue_byte(rand_data());
        end
        queue_byte(midi_rs_pkg::BYTE_SYSEX);
        n = $urandom_range(0, 4);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0:       queue_byte(midi_rs_pkg::BYTE_SYSEX);
            1:       queue_byte(8'($urandom_range(8'h80, 8'hEF)));
            default: queue_byte(rand_data());
          endcase
          maybe_realtime();
        end
        queue_byte(midi_rs_pkg::BYTE_EOX);
        queue_byte(rand_data());
      end else if (pick < 82) begin
        queue_byte(8'($urandom_range(8'hF1, 8'hFF)));
      end else begin
        queue_byte(8'($urandom_range(0, 255)));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (pend_words.size() != 0 || in_valid) @(negedge clk);
    while (expected_msgs.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : timeout_proc
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
